// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

  // Register byte offsets
  localparam logic [11:0] OFF_REV_LO   = 12'h000;
  localparam logic [11:0] OFF_REV_HI   = 12'h004;
  localparam logic [11:0] OFF_SYSC     = 12'h010;
  localparam logic [11:0] OFF_IRQ_RAW  = 12'h024;
  localparam logic [11:0] OFF_IRQ_STAT = 12'h028;
  localparam logic [11:0] OFF_IEN_SET  = 12'h02c;
  localparam logic [11:0] OFF_IEN_CLR  = 12'h030;
  localparam logic [11:0] OFF_WAKE     = 12'h034;
  localparam logic [11:0] OFF_SYSS     = 12'h090;
  localparam logic [11:0] OFF_BUF      = 12'h094;
  localparam logic [11:0] OFF_CNT      = 12'h098;
  localparam logic [11:0] OFF_DATA     = 12'h09c;
  localparam logic [11:0] OFF_CON      = 12'h0a4;
  localparam logic [11:0] OFF_OA       = 12'h0a8;
  localparam logic [11:0] OFF_SA       = 12'h0ac;
  localparam logic [11:0] OFF_PSC      = 12'h0b0;
  localparam logic [11:0] OFF_SCLL     = 12'h0b4;
  localparam logic [11:0] OFF_SCLH     = 12'h0b8;
  localparam logic [11:0] OFF_SYSTEST  = 12'h0bc;
  localparam logic [11:0] OFF_BUFSTAT  = 12'h0c0;

  // Fixed read values
  localparam logic [15:0] REV_LO_VAL  = 16'h0002;
  localparam logic [15:0] REV_HI_VAL  = 16'h5040;
  localparam logic [15:0] SYSS_VAL    = 16'h0001;
  localparam logic [15:0] BUFSTAT_VAL = 16'h8000;

  // Write masks
  localparam logic [15:0] SYSC_WMASK = ~16'h0002;
  localparam logic [15:0] BUF_WMASK  = ~16'h4040;

  // Status bits
  localparam logic [15:0] ST_AL   = 16'h0001;
  localparam logic [15:0] ST_NACK = 16'h0002;
  localparam logic [15:0] ST_ARDY = 16'h0004;
  localparam logic [15:0] ST_RRDY = 16'h0008;
  localparam logic [15:0] ST_XRDY = 16'h0010;
  localparam logic [15:0] ST_BF   = 16'h0100;
  localparam logic [15:0] ST_BB   = 16'h1000;

  // Control bit positions
  localparam int CT_STT = 0;
  localparam int CT_STP = 1;
  localparam int CT_XSA = 8;
  localparam int CT_TRX = 9;
  localparam int CT_MST = 10;
  localparam int CT_EN  = 15;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [11:0] reg_offset;
    logic [15:0] write_data;
    logic        partner_nack;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_line;
    logic        start_issued;
    logic [6:0]  target_address;
    logic        start_is_read;
    logic        byte_sent;
    logic [7:0]  tx_byte;
    logic        byte_fetched;
    logic        stop_issued;
  } rsp_t;

  typedef struct packed {
    logic [15:0] sys_config;
    logic [15:0] latched_status;
    logic [15:0] irq_enable_mask;
    logic [15:0] wakeup_enable;
    logic [15:0] buffer_config;
    logic [15:0] byte_count_setting;
    logic [7:0]  data_byte;
    logic [15:0] control_word;
    logic [15:0] own_address;
    logic [9:0]  target_slave_address;
    logic [7:0]  prescaler;
    logic [7:0]  scl_low_time;
    logic [7:0]  scl_high_time;
    logic [15:0] system_test;
    logic        bus_busy;
    logic        receiving;
    logic [15:0] bytes_remaining;
  } regs_t;

  // Latched bits merged with the live bus bits
  function automatic logic [15:0] live_status(input regs_t s);
    logic [15:0] st;
    st = s.latched_status;
    if (s.bus_busy) begin
      st = st | ST_BB;
      if (s.bytes_remaining != 16'd0) begin
        st = st | (s.receiving ? ST_RRDY : ST_XRDY);
      end
    end else begin
      st = st | ST_BF;
    end
    return st;
  endfunction

endpackage

// ===== design/i2cm_req_if.sv =====
interface i2cm_req_if import i2cm_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_t        command;
  logic [11:0] reg_offset;
  logic [15:0] write_data;
  logic        partner_nack;
  logic [7:0]  rx_byte;

  modport source (
    output valid, command, reg_offset, write_data, partner_nack, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, command, reg_offset, write_data, partner_nack, rx_byte,
    output ready
  );
endinterface

// ===== design/i2cm_rsp_if.sv =====
interface i2cm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_line;
  logic        start_issued;
  logic [6:0]  target_address;
  logic        start_is_read;
  logic        byte_sent;
  logic [7:0]  tx_byte;
  logic        byte_fetched;
  logic        stop_issued;

  modport source (
    output valid, read_data, irq_line, start_issued, target_address, start_is_read,
           byte_sent, tx_byte, byte_fetched, stop_issued,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_line, start_issued, target_address, start_is_read,
           byte_sent, tx_byte, byte_fetched, stop_issued,
    output ready
  );
endinterface

// ===== design/i2c_master_register_model.sv =====
// Register model of a master-only I2C controller, one bus access per item.
// in_item (sink): one register read or write with offset, write data, and
// the bus response (partner nack, received byte) that the access may use.
// out_item (source): one result per item: read data, interrupt line and
// the bus events (start, byte sent, byte fetched, stop) that it caused.
// Items pass an input register, then the decode/update logic, then a result
// register. One item per cycle is taken while the result side keeps up.
// The register state is updated as an item moves from the input register
// into the result register, so back-to-back accesses see each other's
// effects in order. When the receiver stalls, the result register holds,
// the input register fills, and in_item.ready drops until out_item.ready
// returns; nothing is lost or repeated. Synchronous active-low reset
// empties both registers and clears every controller register to zero.
module i2c_master_register_model import i2cm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  i2cm_req_if.sink   in_item,
  i2cm_rsp_if.source out_item
);

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  rsp_t  out_rsp_r;
  regs_t st_r;
  regs_t st_nxt;
  rsp_t  rsp_nxt;
  req_t  in_req;
  logic  out_free;
  logic  s1_adv;
  logic  in_acc;

  // Handshake control
  assign out_free      = !out_valid_r || out_item.ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_item.ready = !s1_valid_r || out_free;
  assign in_acc        = in_item.valid && in_item.ready;

  assign in_req.command      = in_item.command;
  assign in_req.reg_offset   = in_item.reg_offset;
  assign in_req.write_data   = in_item.write_data;
  assign in_req.partner_nack = in_item.partner_nack;
  assign in_req.rx_byte      = in_item.rx_byte;

  i2cm_core u_core (
    .st     (st_r),
    .req    (s1_req_r),
    .st_nxt (st_nxt),
    .rsp    (rsp_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
    if (in_acc) begin
      s1_req_r <= in_req;
    end
  end

  // Controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (s1_adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.read_data      = out_rsp_r.read_data;
  assign out_item.irq_line       = out_rsp_r.irq_line;
  assign out_item.start_issued   = out_rsp_r.start_issued;
  assign out_item.target_address = out_rsp_r.target_address;
  assign out_item.start_is_read  = out_rsp_r.start_is_read;
  assign out_item.byte_sent      = out_rsp_r.byte_sent;
  assign out_item.tx_byte        = out_rsp_r.tx_byte;
  assign out_item.byte_fetched   = out_rsp_r.byte_fetched;
  assign out_item.stop_issued    = out_rsp_r.stop_issued;

  // An item leaving the input register always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item did not reach result register");

  // A byte is never sent and fetched by the same access
  a_send_fetch_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.byte_sent && out_rsp_r.byte_fetched))
    else $error("byte sent and fetched in one access");

  // Start fields are zero unless a start went out
  a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.start_issued) |->
      (out_rsp_r.target_address == 7'd0 && !out_rsp_r.start_is_read))
    else $error("start fields set without a start");

endmodule

// ===== design/i2cm_core.sv =====
module i2cm_core import i2cm_pkg::*; (
  input  regs_t st,
  input  req_t  req,
  output regs_t st_nxt,
  output rsp_t  rsp
);

  regs_t       s;
  rsp_t        r;
  logic        fin;
  logic        rd_dir;
  logic [15:0] wd;

  assign wd = req.write_data;

  // Register access decode and state update for one item
  always_comb begin
    s      = st;
    r      = '0;
    fin    = 1'b0;
    rd_dir = ~wd[CT_TRX];

    if (req.command == CMD_WRITE) begin
      case (req.reg_offset)
        OFF_SYSC:     s.sys_config = wd & SYSC_WMASK;
        OFF_IRQ_RAW:  s.latched_status = st.latched_status | wd;
        OFF_IRQ_STAT: s.latched_status = st.latched_status & ~wd;
        OFF_IEN_SET:  s.irq_enable_mask = st.irq_enable_mask | wd;
        OFF_IEN_CLR:  s.irq_enable_mask = st.irq_enable_mask & ~wd;
        OFF_WAKE:     s.wakeup_enable = wd;
        OFF_BUF:      s.buffer_config = wd & BUF_WMASK;
        OFF_CNT:      s.byte_count_setting = wd;
        OFF_DATA: begin
          // transmit one byte while a send is open
          if (st.bus_busy && !st.receiving && st.bytes_remaining != 16'd0) begin
            r.byte_sent       = 1'b1;
            r.tx_byte         = wd[7:0];
            s.bytes_remaining = st.bytes_remaining - 16'd1;
            fin               = (st.bytes_remaining == 16'd1);
          end
        end
        OFF_CON: begin
          s.control_word = wd;
          if (!wd[CT_EN]) begin
            // module disabled: abort any transfer
            r.stop_issued     = st.bus_busy;
            s.bus_busy        = 1'b0;
            s.bytes_remaining = 16'd0;
            s.latched_status  = 16'd0;
          end else if (wd[CT_STT]) begin
            s.control_word[CT_STT] = 1'b0;
            if (wd[CT_MST] && !wd[CT_XSA]) begin
              r.start_issued   = 1'b1;
              r.target_address = st.target_slave_address[6:0];
              r.start_is_read  = rd_dir;
              if (req.partner_nack) begin
                s.latched_status       = st.latched_status | ST_NACK | ST_ARDY;
                s.bus_busy             = 1'b0;
                s.control_word[CT_STP] = 1'b0;
              end else begin
                s.bus_busy        = 1'b1;
                s.receiving       = rd_dir;
                s.bytes_remaining = st.byte_count_setting;
                if (rd_dir && st.byte_count_setting != 16'd0) begin
                  s.data_byte    = req.rx_byte;
                  r.byte_fetched = 1'b1;
                end
              end
            end
          end
        end
        OFF_OA:      s.own_address = wd;
        OFF_SA:      s.target_slave_address = wd[9:0];
        OFF_PSC:     s.prescaler = wd[7:0];
        OFF_SCLL:    s.scl_low_time = wd[7:0];
        OFF_SCLH:    s.scl_high_time = wd[7:0];
        OFF_SYSTEST: s.system_test = wd;
        default: ;
      endcase
    end else begin
      case (req.reg_offset)
        OFF_REV_LO:   r.read_data = REV_LO_VAL;
        OFF_REV_HI:   r.read_data = REV_HI_VAL;
        OFF_SYSC:     r.read_data = st.sys_config;
        OFF_IRQ_RAW:  r.read_data = live_status(st);
        OFF_IRQ_STAT: r.read_data = live_status(st);
        OFF_IEN_SET:  r.read_data = st.irq_enable_mask;
        OFF_IEN_CLR:  r.read_data = st.irq_enable_mask;
        OFF_WAKE:     r.read_data = st.wakeup_enable;
        OFF_SYSS:     r.read_data = SYSS_VAL;
        OFF_BUF:      r.read_data = st.buffer_config;
        OFF_CNT:      r.read_data = st.bus_busy ? st.bytes_remaining
                                                : st.byte_count_setting;
        OFF_DATA: begin
          r.read_data = {8'd0, st.data_byte};
          // receive: count down, then fetch next byte or finish
          if (st.bus_busy && st.receiving && st.bytes_remaining != 16'd0) begin
            s.bytes_remaining = st.bytes_remaining - 16'd1;
            if (st.bytes_remaining != 16'd1) begin
              s.data_byte    = req.rx_byte;
              r.byte_fetched = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
        end
        OFF_CON:     r.read_data = st.control_word;
        OFF_OA:      r.read_data = st.own_address;
        OFF_SA:      r.read_data = {6'd0, st.target_slave_address};
        OFF_PSC:     r.read_data = {8'd0, st.prescaler};
        OFF_SCLL:    r.read_data = {8'd0, st.scl_low_time};
        OFF_SCLH:    r.read_data = {8'd0, st.scl_high_time};
        OFF_SYSTEST: r.read_data = st.system_test;
        OFF_BUFSTAT: r.read_data = BUFSTAT_VAL;
        default:     r.read_data = 16'd0;
      endcase
    end

    // transfer completion
    if (fin) begin
      s.latched_status       = s.latched_status | ST_ARDY;
      s.control_word[CT_MST] = 1'b0;
      if (s.control_word[CT_STP]) begin
        r.stop_issued          = 1'b1;
        s.control_word[CT_STP] = 1'b0;
        s.bus_busy             = 1'b0;
      end
    end

    r.irq_line = ((live_status(s) & s.irq_enable_mask) != 16'd0);
  end

  assign st_nxt = s;
  assign rsp    = r;

endmodule

// ===== tb/tb_i2c_master_register_model.sv =====
`timescale 1ns / 100ps

module tb_i2c_master_register_model;
  import i2cm_pkg::*;

  localparam logic [11:0] OFF_HOLE = 12'hfff;   // nothing is mapped here
  localparam int RANDOM_ACCESSES = 1450;
  localparam int PRINT_CAP = 40;

  localparam logic [11:0] REG_MAP [20] = '{
    OFF_REV_LO, OFF_REV_HI, OFF_SYSC, OFF_IRQ_RAW, OFF_IRQ_STAT, OFF_IEN_SET,
    OFF_IEN_CLR, OFF_WAKE, OFF_SYSS, OFF_BUF, OFF_CNT, OFF_DATA, OFF_CON,
    OFF_OA, OFF_SA, OFF_PSC, OFF_SCLL, OFF_SCLH, OFF_SYSTEST, OFF_BUFSTAT
  };

  // one directed access; want is used only where typed is set
  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] off;
    logic [15:0] wd;
    logic        nack;
    logic [7:0]  rx;
    logic        typed;
    logic [15:0] want;
  } step_t;

  localparam int N_DIRECTED = 28;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // fixed registers and status right after reset
    '{CMD_READ,  OFF_REV_LO,   16'h0000, 1'b0, 8'h00, 1'b1, REV_LO_VAL},
    '{CMD_READ,  OFF_REV_HI,   16'h0000, 1'b0, 8'h00, 1'b1, REV_HI_VAL},
    '{CMD_READ,  OFF_SYSS,     16'h0000, 1'b0, 8'h00, 1'b1, SYSS_VAL},
    '{CMD_READ,  OFF_BUFSTAT,  16'h0000, 1'b0, 8'h00, 1'b1, BUFSTAT_VAL},
    '{CMD_READ,  OFF_HOLE,     16'h0000, 1'b0, 8'h00, 1'b1, 16'h0000},
    '{CMD_READ,  OFF_IRQ_STAT, 16'h0000, 1'b0, 8'h00, 1'b1, ST_BF},
    // writes that must have no effect
    '{CMD_WRITE, OFF_REV_LO,   16'hffff, 1'b0, 8'h00, 1'b1, 16'h0000},
    '{CMD_WRITE, OFF_HOLE,     16'hffff, 1'b0, 8'h00, 1'b1, 16'h0000},
    // masked writes, irq enable, slave address and byte count
    '{CMD_WRITE, OFF_SYSC,     16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_BUF,      16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_IEN_SET,  16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_SA,       16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_CNT,      16'h0002, 1'b0, 8'h00, 1'b0, 16'h0000},
    // transmit two bytes: EN|MST|TRX|STT, no stop at the end
    '{CMD_WRITE, OFF_CON,      16'h8601, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_DATA,     16'h00ff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_DATA,     16'hff00, 1'b0, 8'h00, 1'b0, 16'h0000},
    // repeated start while the bus is held, receive with stop
    '{CMD_WRITE, OFF_CON,      16'h8403, 1'b0, 8'hff, 1'b0, 16'h0000},
    '{CMD_READ,  OFF_DATA,     16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_READ,  OFF_DATA,     16'h0000, 1'b0, 8'hff, 1'b0, 16'h0000},
    // start not acknowledged
    '{CMD_WRITE, OFF_CON,      16'h8403, 1'b1, 8'hff, 1'b0, 16'h0000},
    // refused starts: 10-bit addressing, slave mode
    '{CMD_WRITE, OFF_CON,      16'h8501, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_CON,      16'h8001, 1'b0, 8'h00, 1'b0, 16'h0000},
    // receive with a zero count, then abort by disabling
    '{CMD_WRITE, OFF_CNT,      16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_CON,      16'h8401, 1'b0, 8'hff, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_CON,      16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000},
    // raw status set, status clear, enable clear
    '{CMD_WRITE, OFF_IRQ_RAW,  16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_IRQ_STAT, 16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{CMD_WRITE, OFF_IEN_CLR,  16'hffff, 1'b0, 8'h00, 1'b0, 16'h0000}
  };

  logic clk;
  logic rst_n;

  i2cm_req_if in_item ();
  i2cm_rsp_if out_item ();

  i2c_master_register_model uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // controller state as seen by the predictor
  regs_t ctl;
  rsp_t  access_results [$];
  int    errors;
  int    sent_count;
  int    burst_left;

  always #5 clk = ~clk;

  // status with the live bus bits folded in
  function automatic logic [15:0] bus_status();
    logic [15:0] bus_bits;
    if (!ctl.bus_busy) begin
      bus_bits = ST_BF;
    end else if (ctl.bytes_remaining == 16'd0) begin
      bus_bits = ST_BB;
    end else begin
      bus_bits = ST_BB | (ctl.receiving ? ST_RRDY : ST_XRDY);
    end
    return ctl.latched_status | bus_bits;
  endfunction

  // last byte moved: ARDY, master off, optional stop
  function automatic void close_transfer(inout rsp_t o);
    ctl.latched_status = ctl.latched_status | ST_ARDY;
    ctl.control_word[CT_MST] = 1'b0;
    if (ctl.control_word[CT_STP]) begin
      o.stop_issued = 1'b1;
      ctl.control_word[CT_STP] = 1'b0;
      ctl.bus_busy = 1'b0;
    end
  endfunction

  function automatic rsp_t apply_register_access(req_t a);
    rsp_t o;
    logic rd;
    o = '0;
    if (a.command == CMD_WRITE) begin
      case (a.reg_offset)
        OFF_SYSC:     ctl.sys_config = a.write_data & SYSC_WMASK;
        OFF_IRQ_RAW:  ctl.latched_status = ctl.latched_status | a.write_data;
        OFF_IRQ_STAT: ctl.latched_status = ctl.latched_status & ~a.write_data;
        OFF_IEN_SET:  ctl.irq_enable_mask = ctl.irq_enable_mask | a.write_data;
        OFF_IEN_CLR:  ctl.irq_enable_mask = ctl.irq_enable_mask & ~a.write_data;
        OFF_WAKE:     ctl.wakeup_enable = a.write_data;
        OFF_BUF:      ctl.buffer_config = a.write_data & BUF_WMASK;
        OFF_CNT:      ctl.byte_count_setting = a.write_data;
        OFF_DATA: begin
          if (ctl.bus_busy && !ctl.receiving && ctl.bytes_remaining != 16'd0) begin
            o.byte_sent = 1'b1;
            o.tx_byte = a.write_data[7:0];
            ctl.bytes_remaining = ctl.bytes_remaining - 16'd1;
            if (ctl.bytes_remaining == 16'd0) close_transfer(o);
          end
        end
        OFF_CON: begin
          ctl.control_word = a.write_data;
          if (!a.write_data[CT_EN]) begin
            // disable aborts whatever is going on
            o.stop_issued = ctl.bus_busy;
            ctl.bus_busy = 1'b0;
            ctl.bytes_remaining = 16'd0;
            ctl.latched_status = 16'd0;
          end else if (a.write_data[CT_STT]) begin
            ctl.control_word[CT_STT] = 1'b0;
            if (a.write_data[CT_MST] && !a.write_data[CT_XSA]) begin
              rd = ~a.write_data[CT_TRX];
              o.start_issued = 1'b1;
              o.target_address = ctl.target_slave_address[6:0];
              o.start_is_read = rd;
              if (a.partner_nack) begin
                ctl.latched_status = ctl.latched_status | ST_NACK | ST_ARDY;
                ctl.bus_busy = 1'b0;
                ctl.control_word[CT_STP] = 1'b0;
              end else begin
                ctl.bus_busy = 1'b1;
                ctl.receiving = rd;
                ctl.bytes_remaining = ctl.byte_count_setting;
                if (rd && ctl.bytes_remaining != 16'd0) begin
                  ctl.data_byte = a.rx_byte;
                  o.byte_fetched = 1'b1;
                end
              end
            end
          end
        end
        OFF_OA:       ctl.own_address = a.write_data;
        OFF_SA:       ctl.target_slave_address = a.write_data[9:0];
        OFF_PSC:      ctl.prescaler = a.write_data[7:0];
        OFF_SCLL:     ctl.scl_low_time = a.write_data[7:0];
        OFF_SCLH:     ctl.scl_high_time = a.write_data[7:0];
        OFF_SYSTEST:  ctl.system_test = a.write_data;
        default: ;
      endcase
    end else begin
      case (a.reg_offset)
        OFF_REV_LO:   o.read_data = REV_LO_VAL;
        OFF_REV_HI:   o.read_data = REV_HI_VAL;
        OFF_SYSC:     o.read_data = ctl.sys_config;
        OFF_IRQ_RAW, OFF_IRQ_STAT: o.read_data = bus_status();
        OFF_IEN_SET, OFF_IEN_CLR:  o.read_data = ctl.irq_enable_mask;
        OFF_WAKE:     o.read_data = ctl.wakeup_enable;
        OFF_SYSS:     o.read_data = SYSS_VAL;
        OFF_BUF:      o.read_data = ctl.buffer_config;
        OFF_CNT:      o.read_data = ctl.bus_busy ? ctl.bytes_remaining
                                                 : ctl.byte_count_setting;
        OFF_DATA: begin
          o.read_data = {8'h00, ctl.data_byte};
          if (ctl.bus_busy && ctl.receiving && ctl.bytes_remaining != 16'd0) begin
            ctl.bytes_remaining = ctl.bytes_remaining - 16'd1;
            if (ctl.bytes_remaining != 16'd0) begin
              ctl.data_byte = a.rx_byte;
              o.byte_fetched = 1'b1;
            end else begin
              close_transfer(o);
            end
          end
        end
        OFF_CON:      o.read_data = ctl.control_word;
        OFF_OA:       o.read_data = ctl.own_address;
        OFF_SA:       o.read_data = {6'h00, ctl.target_slave_address};
        OFF_PSC:      o.read_data = {8'h00, ctl.prescaler};
        OFF_SCLL:     o.read_data = {8'h00, ctl.scl_low_time};
        OFF_SCLH:     o.read_data = {8'h00, ctl.scl_high_time};
        OFF_SYSTEST:  o.read_data = ctl.system_test;
        OFF_BUFSTAT:  o.read_data = BUFSTAT_VAL;
        default:      o.read_data = 16'h0000;
      endcase
    end
    o.irq_line = |(bus_status() & ctl.irq_enable_mask);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // present one item, sender may idle between bursts; predicts on acceptance
  task automatic send_access(cmd_t c, logic [11:0] off, logic [15:0] wd, logic nk,
                             logic [7:0] rx, logic typed, logic [15:0] typed_rd);
    int gap;
    req_t r;
    rsp_t pred;
    r.command = c;
    r.reg_offset = off;
    r.write_data = wd;
    r.partner_nack = nk;
    r.rx_byte = rx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        in_item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_item.valid        <= 1'b1;
    in_item.command      <= r.command;
    in_item.reg_offset   <= r.reg_offset;
    in_item.write_data   <= r.write_data;
    in_item.partner_nack <= r.partner_nack;
    in_item.rx_byte      <= r.rx_byte;
    @(posedge clk);
    while (in_item.ready !== 1'b1) @(posedge clk);
    pred = apply_register_access(r);
    if (typed) begin
      pred = '0;
      pred.read_data = typed_rd;
    end
    access_results.push_back(pred);
    burst_left--;
    sent_count++;
  endtask

  task automatic random_access();
    logic [11:0] off;
    off = ($urandom_range(0, 3) == 0) ? 12'($urandom) : REG_MAP[$urandom_range(0, 19)];
    send_access(cmd_t'($urandom_range(0, 1)), off, 16'($urandom), 1'($urandom),
                8'($urandom), 1'b0, 16'h0000);
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    in_item.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (access_results.size() > 0) @(posedge clk);
  endtask

  // optional address, count, start, then the data accesses, with noise mixed in
  task automatic random_transfer();
    logic [15:0] cnt;
    logic [15:0] con;
    logic [15:0] off_word;
    logic        rd;
    logic        wrong;
    int          steps;
    if ($urandom_range(0, 1) == 1) begin
      send_access(CMD_WRITE, OFF_SA, 16'($urandom), 1'b0, 8'($urandom), 1'b0, 16'h0000);
    end
    case ($urandom_range(0, 9))
      0:       cnt = 16'($urandom);
      1, 2:    cnt = 16'($urandom_range(5, 12));
      default: cnt = 16'($urandom_range(0, 4));
    endcase
    send_access(CMD_WRITE, OFF_CNT, cnt, 1'($urandom), 8'($urandom), 1'b0, 16'h0000);
    con = 16'($urandom) & 16'h78fc;
    con[CT_EN]  = 1'b1;
    con[CT_STT] = 1'b1;
    con[CT_MST] = ($urandom_range(0, 11) != 0);
    con[CT_XSA] = ($urandom_range(0, 11) == 0);
    con[CT_TRX] = 1'($urandom_range(0, 1));
    con[CT_STP] = 1'($urandom_range(0, 1));
    rd = ~con[CT_TRX];
    send_access(CMD_WRITE, OFF_CON, con, ($urandom_range(0, 7) == 0), 8'($urandom),
                1'b0, 16'h0000);
    steps = (cnt > 16'd12) ? int'($urandom_range(1, 12)) : int'(cnt) + int'($urandom_range(0, 1));
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 4) == 0) random_access();
      if ($urandom_range(0, 40) == 0) begin
        // abort mid-transfer
        off_word = 16'($urandom);
        off_word[CT_EN] = 1'b0;
        send_access(CMD_WRITE, OFF_CON, off_word, 1'($urandom), 8'($urandom), 1'b0, 16'h0000);
        break;
      end
      wrong = ($urandom_range(0, 15) == 0);
      send_access((rd ^ wrong) ? CMD_READ : CMD_WRITE, OFF_DATA, 16'($urandom),
                  1'($urandom), 8'($urandom), 1'b0, 16'h0000);
    end
  endtask

  // receiver stall pattern, sometimes fully open
  int          pat_age;
  logic [15:0] ready_pattern;
  always @(posedge clk) begin
    if (pat_age == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      pat_age = 64;
    end
    pat_age--;
    out_item.ready <= ready_pattern[pat_age % 16];
  end

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_item.valid === 1'b1 && out_item.ready === 1'b1) begin
      if (access_results.size() == 0) begin
        report_mismatch("result with no pending access");
      end else begin
        want = access_results.pop_front();
        check_field("read_data", out_item.read_data, want.read_data);
        check_field("irq_line", 16'(out_item.irq_line), 16'(want.irq_line));
        check_field("start_issued", 16'(out_item.start_issued), 16'(want.start_issued));
        check_field("target_address", 16'(out_item.target_address),
                    16'(want.target_address));
        check_field("start_is_read", 16'(out_item.start_is_read), 16'(want.start_is_read));
        check_field("byte_sent", 16'(out_item.byte_sent), 16'(want.byte_sent));
        check_field("tx_byte", 16'(out_item.tx_byte), 16'(want.tx_byte));
        check_field("byte_fetched", 16'(out_item.byte_fetched), 16'(want.byte_fetched));
        check_field("stop_issued", 16'(out_item.stop_issued), 16'(want.stop_issued));
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    sent_count = 0;
    burst_left = 0;
    pat_age = 0;
    ready_pattern = 16'hffff;
    ctl = '0;
    in_item.valid = 1'b0;
    in_item.command = CMD_READ;
    in_item.reg_offset = 12'h000;
    in_item.write_data = 16'h0000;
    in_item.partner_nack = 1'b0;
    in_item.rx_byte = 8'h00;
    out_item.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_access(DIRECTED[i].cmd, DIRECTED[i].off, DIRECTED[i].wd, DIRECTED[i].nack,
                  DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain_results();

    // random: mostly well-formed transfers, some noise, occasional hold-off
    while (sent_count < RANDOM_ACCESSES) begin
      if ($urandom_range(0, 3) == 0) random_access();
      else random_transfer();
      if ($urandom_range(0, 40) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (access_results.size() > 0) report_mismatch("results still pending at end");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
